// ===== rtl/core/rcwt_pkg.sv =====
// Package: widths, codes, result type and defaults for the wall column texturer.
`default_nettype none
package rcwt_pkg;

    localparam int W_COLOR   = 32;
    localparam int W_SH      = 12;
    localparam int W_TEX     = 13;
    localparam int W_ROW     = 12;
    localparam int W_LH      = 16;
    localparam int W_POS     = 26;
    localparam int W_RAY     = 19;
    localparam int W_OROW    = 11;
    localparam int W_TXY     = 12;
    localparam int W_ACC     = 32;
    localparam int W_OFF     = 18;
    localparam int W_OFF_MAG = 17;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_SCREEN_ROWS_DEF = 2048;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_TEX_SIZE_DEF    = 4096;

    localparam logic [W_SH-1:0]  SH_RESET  = 12'd1024;
    localparam logic [W_TEX-1:0] TEX_RESET = 13'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_H    = 3'd4;

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] REGION_CEIL  = 2'd0;
    localparam logic [1:0] REGION_WALL  = 2'd1;
    localparam logic [1:0] REGION_FLOOR = 2'd2;
    localparam logic [1:0] REGION_NONE  = 2'd3;

    localparam logic [1:0] SIDE_N = 2'd0;
    localparam logic [1:0] SIDE_S = 2'd1;
    localparam logic [1:0] SIDE_W = 2'd2;
    localparam logic [1:0] SIDE_E = 2'd3;

    typedef struct packed {
        logic [W_OROW-1:0]  row;
        logic [1:0]         region;
        logic [W_COLOR-1:0] flat_color;
        logic [1:0]         texture_side;
        logic [W_TXY-1:0]   texel_x;
        logic [W_TXY-1:0]   texel_y;
        logic               texel_valid;
        logic               last_row;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/rcwt_item_if.sv =====
// Interface: input item channel of the wall column texturer.
`default_nettype none
interface rcwt_item_if
    import rcwt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [W_ROW-1:0]         slice_start;
    logic [W_ROW-1:0]         slice_end;
    logic [W_LH-1:0]          line_height;
    logic                     hit_on_y_wall;
    logic [W_POS-1:0]         player_x;
    logic [W_POS-1:0]         player_y;
    logic signed [W_RAY-1:0]  ray_dir_x;
    logic signed [W_RAY-1:0]  ray_dir_y;
    logic [W_POS-1:0]         wall_distance;

    modport source (output valid, operation, slice_start, slice_end, line_height,
                    hit_on_y_wall, player_x, player_y, ray_dir_x, ray_dir_y,
                    wall_distance, input ready);
    modport sink (input valid, operation, slice_start, slice_end, line_height,
                  hit_on_y_wall, player_x, player_y, ray_dir_x, ray_dir_y,
                  wall_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rcwt_result_if.sv =====
// Interface: result channel of the wall column texturer.
`default_nettype none
interface rcwt_result_if
    import rcwt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [W_OROW-1:0]  row;
    logic [1:0]         region;
    logic [W_COLOR-1:0] flat_color;
    logic [1:0]         texture_side;
    logic [W_TXY-1:0]   texel_x;
    logic [W_TXY-1:0]   texel_y;
    logic               texel_valid;
    logic               last_row;

    modport source (output valid, row, region, flat_color, texture_side, texel_x,
                    texel_y, texel_valid, last_row, input ready);
    modport sink (input valid, row, region, flat_color, texture_side, texel_x,
                  texel_y, texel_valid, last_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rcwt_div.sv =====
// Shared restoring divider: one quotient bit per cycle, left-aligned dividend.
`default_nettype none
module rcwt_div
    import rcwt_pkg::*;
#(
    parameter int DW = 46,
    parameter int VW = 16,
    localparam int NBW = $clog2(DW + 1)
)(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DW-1:0]  i_dividend,
    input  wire logic [VW-1:0]  i_divisor,
    input  wire logic [NBW-1:0] i_nbits,
    output logic                o_done,
    output logic [DW-1:0]       o_quot,
    output logic [VW-1:0]       o_rem
);
    logic [DW-1:0]  r_dvd;
    logic [DW-1:0]  r_quo;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_div;
    logic [NBW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [VW:0]    trial;
    logic [VW:0]    diff;
    logic           ge;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == NBW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= i_nbits;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_cnt <= r_cnt - NBW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== rtl/core/raycast_wall_column_texturer_core.sv =====
// Top level: raycaster wall column texturer with a shared sequential divider.
// A setup transfer runs two multiply steps, then the texel-row step and start divisions
// one bit per cycle through the one restoring divider; no new item is taken until both
// are done. Ceiling and floor rows go straight to the output register; a wall row runs
// the texel-row remainder through the same divider, and no new item is taken until it
// is done. No new item is taken while a finished result waits in the output register,
// unless it transfers in that cycle.
`default_nettype none
module raycast_wall_column_texturer_core
    import rcwt_pkg::*;
#(
    parameter int MAX_SCREEN_ROWS = MAX_SCREEN_ROWS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_TEX_SIZE    = MAX_TEX_SIZE_DEF
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [W_COLOR-1:0]   i_cfg_data,
    rcwt_item_if.sink                 i_item,
    rcwt_result_if.source             o_result
);
    localparam int FW   = 2 * FRAC_BITS;
    localparam int OTW  = W_OFF_MAG + W_TEX;
    localparam int DW   = OTW + FRAC_BITS;
    localparam int NBW  = $clog2(DW + 1);
    localparam int PIXW = W_ACC - FRAC_BITS;
    localparam int PRW  = W_POS + W_RAY + 1;
    localparam int HITW = PRW + FRAC_BITS + 1;
    localparam int TXW  = FW + W_TEX;
    localparam logic [W_TEX-1:0] SH_MAX  = W_TEX'(MAX_SCREEN_ROWS);
    localparam logic [W_TEX-1:0] TEX_MAX = W_TEX'(MAX_TEX_SIZE);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_MUL_A      = 8'b0000_0010,
        ST_MUL_B      = 8'b0000_0100,
        ST_STEP_DIV   = 8'b0000_1000,
        ST_STEP_WAIT  = 8'b0001_0000,
        ST_START_DIV  = 8'b0010_0000,
        ST_START_WAIT = 8'b0100_0000,
        ST_PIX_WAIT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [W_COLOR-1:0] r_ceil, r_floor;
    logic [W_SH-1:0]    r_sh;
    logic [W_TEX-1:0]   r_tw, r_th;
    logic [W_TEX-1:0]   sh_cl, tw_cl, th_cl;

    logic [W_ROW-1:0]        r_row, r_wfr, r_wer;
    logic [1:0]              r_side;
    logic                    r_mirror;
    logic [W_POS-1:0]        r_pos, r_dist;
    logic signed [W_RAY-1:0] r_ray;
    logic [W_LH-1:0]         r_lh;
    logic [W_TEX-1:0]        r_col_tx;
    logic [W_ACC-1:0]        r_accum, r_step;
    logic                    r_active;

    logic signed [PRW-1:0]   r_prod;
    logic [OTW-1:0]          r_offth;
    logic                    r_offneg;
    logic [TXW-1:0]          r_txp;
    logic                    r_pix_neg;

    t_result r_out, n_out;
    logic    r_out_valid;

    logic in_fire, out_fire, setup_fire, pix_fire, wall_row, last_hit;
    logic signed [HITW-1:0]  hit;
    logic signed [W_OFF-1:0] off;
    logic [W_OFF_MAG-1:0]    off_mag;
    logic [W_TEX-1:0]        tx;
    logic [W_ACC:0]          acc_sum;
    logic [W_ACC-1:0]        acc_next, acc_abs;

    logic           div_start, div_done;
    logic [DW-1:0]  div_dvd, div_quot;
    logic [W_LH-1:0] div_dvs, div_rem;
    logic [NBW-1:0] div_nbits;
    logic [DW:0]    q_ceil;
    logic [W_ACC-1:0] step_sat, start_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil  <= '0;
            r_floor <= '0;
            r_sh    <= SH_RESET;
            r_tw    <= TEX_RESET;
            r_th    <= TEX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CEILING:  r_ceil  <= i_cfg_data;
                CFG_FLOOR:    r_floor <= i_cfg_data;
                CFG_SCREEN_H: r_sh    <= i_cfg_data[W_SH-1:0];
                CFG_TEX_W:    r_tw    <= i_cfg_data[W_TEX-1:0];
                CFG_TEX_H:    r_th    <= i_cfg_data[W_TEX-1:0];
                default: ;
            endcase
        end
    end

    assign sh_cl = (r_sh == '0) ? W_TEX'(1) :
                   ({1'b0, r_sh} > SH_MAX) ? SH_MAX : {1'b0, r_sh};
    assign tw_cl = (r_tw == '0) ? W_TEX'(1) : (r_tw > TEX_MAX) ? TEX_MAX : r_tw;
    assign th_cl = (r_th == '0) ? W_TEX'(1) : (r_th > TEX_MAX) ? TEX_MAX : r_th;

    // handshake
    assign i_item.ready = (r_state == ST_IDLE) && (!r_out_valid || o_result.ready);
    assign in_fire    = i_item.valid && i_item.ready;
    assign out_fire   = r_out_valid && o_result.ready;
    assign setup_fire = in_fire && (i_item.operation == OP_SETUP);
    assign pix_fire   = in_fire && (i_item.operation == OP_PIXEL) && r_active;
    assign wall_row   = (r_row >= r_wfr) && (r_row < r_wer);
    assign last_hit   = ({1'b0, r_row} + W_TEX'(1)) >= sh_cl;

    // setup arithmetic
    assign hit = HITW'($signed({1'b0, r_pos, {FRAC_BITS{1'b0}}})) + HITW'(r_prod);
    assign off = $signed({6'b0, r_wfr}) - $signed({6'b0, sh_cl[W_TEX-1:1]})
               + $signed({3'b0, r_lh[W_LH-1:1]});
    assign off_mag = off[W_OFF-1] ? W_OFF_MAG'(-off) : off[W_OFF_MAG-1:0];
    assign tx = r_txp[FW +: W_TEX];

    // accumulator
    assign acc_sum  = {r_accum[W_ACC-1], r_accum} + {r_step[W_ACC-1], r_step};
    assign acc_next = (acc_sum[W_ACC] != acc_sum[W_ACC-1]) ?
                      {acc_sum[W_ACC], {(W_ACC-1){~acc_sum[W_ACC]}}} : acc_sum[W_ACC-1:0];
    assign acc_abs  = r_accum[W_ACC-1] ? (~r_accum + W_ACC'(1)) : r_accum;

    // divider operands
    always_comb begin
        div_start = 1'b0;
        case (r_state)
            ST_STEP_DIV: begin
                div_start = 1'b1;
                div_dvd   = {th_cl, {(DW-W_TEX){1'b0}}};
                div_dvs   = r_lh;
                div_nbits = NBW'(W_TEX + FRAC_BITS);
            end
            ST_START_DIV: begin
                div_start = 1'b1;
                div_dvd   = {r_offth, {FRAC_BITS{1'b0}}};
                div_dvs   = r_lh;
                div_nbits = NBW'(DW);
            end
            default: begin
                div_start = pix_fire && wall_row;
                div_dvd   = {acc_abs[W_ACC-1:FRAC_BITS], {(DW-PIXW){1'b0}}};
                div_dvs   = {{(W_LH-W_TEX){1'b0}}, th_cl};
                div_nbits = NBW'(PIXW);
            end
        endcase
    end

    rcwt_div #(.DW(DW), .VW(W_LH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_nbits    (div_nbits),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign step_sat = (|div_quot[DW-1:W_ACC-1]) ? {1'b0, {(W_ACC-1){1'b1}}} :
                                                 div_quot[W_ACC-1:0];
    assign q_ceil   = {1'b0, div_quot} + (DW+1)'(div_rem != '0);
    always_comb begin
        if (r_offneg) begin
            if ((|q_ceil[DW:W_ACC]) || (q_ceil[W_ACC-1] && (|q_ceil[W_ACC-2:0])))
                start_sat = {1'b1, {(W_ACC-1){1'b0}}};
            else
                start_sat = ~q_ceil[W_ACC-1:0] + W_ACC'(1);
        end else begin
            start_sat = step_sat;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (setup_fire)
                    n_state = ST_MUL_A;
                else if (pix_fire && wall_row)
                    n_state = ST_PIX_WAIT;
            end
            ST_MUL_A:      n_state = ST_MUL_B;
            ST_MUL_B:      n_state = ST_STEP_DIV;
            ST_STEP_DIV:   n_state = ST_STEP_WAIT;
            ST_STEP_WAIT:  if (div_done) n_state = ST_START_DIV;
            ST_START_DIV:  n_state = ST_START_WAIT;
            ST_START_WAIT: if (div_done) n_state = ST_IDLE;
            ST_PIX_WAIT:   if (div_done) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_row       <= '0;
            r_wfr       <= '0;
            r_wer       <= '0;
            r_side      <= SIDE_N;
            r_col_tx    <= '0;
            r_accum     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((in_fire && i_item.operation == OP_PIXEL && !(r_active && wall_row))
                || (r_state == ST_PIX_WAIT && div_done))
                r_out_valid <= 1'b1;
            else if (out_fire)
                r_out_valid <= 1'b0;
            if (setup_fire) begin
                r_wfr <= i_item.slice_start;
                r_wer <= i_item.slice_end;
                if (i_item.hit_on_y_wall)
                    r_side <= (i_item.ray_dir_y <= 0) ? SIDE_N : SIDE_S;
                else
                    r_side <= (i_item.ray_dir_x <= 0) ? SIDE_W : SIDE_E;
            end
            if (pix_fire) begin
                if (wall_row)
                    r_accum <= acc_next;
                if (last_hit)
                    r_active <= 1'b0;
                else
                    r_row <= r_row + W_ROW'(1);
            end
            if (r_state == ST_STEP_DIV)
                r_col_tx <= r_mirror ? (tw_cl - tx - W_TEX'(1)) : tx;
            if (r_state == ST_STEP_WAIT && div_done)
                r_step <= step_sat;
            if (r_state == ST_START_WAIT && div_done) begin
                r_accum  <= start_sat;
                r_row    <= '0;
                r_active <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (setup_fire) begin
            r_mirror <= (!i_item.hit_on_y_wall && i_item.ray_dir_x > 0)
                     || (i_item.hit_on_y_wall && i_item.ray_dir_y < 0);
            r_pos  <= i_item.hit_on_y_wall ? i_item.player_x : i_item.player_y;
            r_ray  <= i_item.hit_on_y_wall ? i_item.ray_dir_x : i_item.ray_dir_y;
            r_dist <= i_item.wall_distance;
            r_lh   <= (i_item.line_height == '0) ? W_LH'(1) : i_item.line_height;
        end
        if (r_state == ST_MUL_A) begin
            r_prod   <= $signed({1'b0, r_dist}) * r_ray;
            r_offth  <= OTW'(off_mag) * OTW'(th_cl);
            r_offneg <= off[W_OFF-1];
        end
        if (r_state == ST_MUL_B)
            r_txp <= TXW'(hit[FW-1:0]) * TXW'(tw_cl);
        if (pix_fire && wall_row)
            r_pix_neg <= r_accum[W_ACC-1];
    end

    // result register
    always_comb begin
        n_out = r_out;
        if (in_fire && i_item.operation == OP_PIXEL) begin
            n_out = '0;
            if (!r_active) begin
                n_out.region = REGION_NONE;
            end else begin
                n_out.row      = r_row[W_OROW-1:0];
                n_out.last_row = last_hit;
                if (r_row < r_wfr) begin
                    n_out.region     = REGION_CEIL;
                    n_out.flat_color = r_ceil;
                end else if (r_row < r_wer) begin
                    n_out.region       = REGION_WALL;
                    n_out.texture_side = r_side;
                    n_out.texel_x      = r_col_tx[W_TXY-1:0];
                end else begin
                    n_out.region     = REGION_FLOOR;
                    n_out.flat_color = r_floor;
                end
            end
        end else if (r_state == ST_PIX_WAIT && div_done) begin
            n_out.texel_y     = r_pix_neg ? '0 : div_rem[W_TXY-1:0];
            n_out.texel_valid = !r_pix_neg || (div_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.row          = r_out.row;
    assign o_result.region       = r_out.region;
    assign o_result.flat_color   = r_out.flat_color;
    assign o_result.texture_side = r_out.texture_side;
    assign o_result.texel_x      = r_out.texel_x;
    assign o_result.texel_y      = r_out.texel_y;
    assign o_result.texel_valid  = r_out.texel_valid;
    assign o_result.last_row     = r_out.last_row;
endmodule
`default_nettype wire

// ===== rtl/core/rcwt_checker.sv =====
// Checker: port-level properties of the wall column texturer, bound to the top level.
`default_nettype none
module rcwt_checker
    import rcwt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_in_op,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [W_OROW-1:0]  i_out_row,
    input wire logic [1:0]         i_out_region,
    input wire logic [W_COLOR-1:0] i_out_flat,
    input wire logic [W_TXY-1:0]   i_out_texel_x,
    input wire logic [W_TXY-1:0]   i_out_texel_y,
    input wire logic               i_out_texel_valid,
    input wire logic               i_out_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row)
            && $stable(i_out_region))
        else $error("stalled result changed");

    a_setup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == OP_SETUP && !i_out_valid |=> !i_out_valid)
        else $error("setup transfer produced a result");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_region == REGION_NONE |->
            i_out_row == '0 && i_out_flat == '0 && !i_out_texel_valid && !i_out_last)
        else $error("no-pixel result carries data");

    a_flat_no_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_region == REGION_CEIL || i_out_region == REGION_FLOOR) |->
            i_out_texel_x == '0 && i_out_texel_y == '0 && !i_out_texel_valid)
        else $error("flat row carries texel data");

    a_wall_no_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_region == REGION_WALL |-> i_out_flat == '0)
        else $error("wall row carries flat colour");
endmodule

bind raycast_wall_column_texturer_core rcwt_checker u_rcwt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_item.valid),
    .i_in_ready        (i_item.ready),
    .i_in_op           (i_item.operation),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_row         (o_result.row),
    .i_out_region      (o_result.region),
    .i_out_flat        (o_result.flat_color),
    .i_out_texel_x     (o_result.texel_x),
    .i_out_texel_y     (o_result.texel_y),
    .i_out_texel_valid (o_result.texel_valid),
    .i_out_last        (o_result.last_row)
);
`default_nettype wire
